// File: src/ole_pkg.sv
// Shared types, constants and codes for the ordered list engine.
package ole_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int OPC_W         = 3;
    localparam int POS_W         = 6;
    localparam int KEY_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int FOUND_W       = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_BEFORE = 3'd0,
        OP_INS_START  = 3'd1,
        OP_APPEND     = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_OVERWRITE  = 3'd4,
        OP_FIND       = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Datapath micro-commands issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START_GROW,
        DP_START_SHRINK,
        DP_START_SCAN,
        DP_MOVE_RD,
        DP_MOVE_WR,
        DP_PUT,
        DP_DROP,
        DP_OVERWRITE,
        DP_SCAN_NEXT,
        DP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_SHRINK,
        MODE_SCAN
    } mode_t;

    typedef struct packed {
        dp_op_t  op;
        status_t st;
        logic    hit;
    } cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic             legal;
        logic             full;
        logic             grow;
        logic             more;
        logic             match;
        logic             last;
    } dp_stat_t;

endpackage

// File: src/ordered_list_engine_top.sv
// Ordered list engine: one request in, one result out, entries kept in a RAM.
// Overwrite, errors and unused codes finish without walking the list; insert/append/remove
// move entries one at a time, and find compares entries from the given position onward.
// Each entry move or compare waits for the registered read of the list RAM.
// A new request is taken the cycle after the previous result is registered.
// Reset clears the count and handshakes; list contents are undefined until written.
module ordered_list_engine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ole_pkg::OPC_W-1:0]           opcode,
    input  logic [ole_pkg::POS_W-1:0]           position,
    input  logic [ole_pkg::KEY_W-1:0]           element_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ole_pkg::STATUS_W-1:0]        status,
    output logic signed [ole_pkg::FOUND_W-1:0]  found_position,
    output logic [ole_pkg::CNT_W-1:0]           entry_count
);
    import ole_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ole_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .position       (position),
        .element_key    (element_key),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    // Count never exceeds the list capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A full status only appears with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> entry_count == CNT_W'(CAPACITY))
        else $error("full status with room left");

    // A match position is only reported by a good request and lies inside the list
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found_position != -7'sd1) |->
            (status == ST_OK && CNT_W'(found_position) < entry_count))
        else $error("match position with bad status or outside list");

    // No request is taken while one is in progress
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

endmodule

// File: src/ole_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/ole_datapath.sv
// Datapath: list memory, entry count, request registers, walk index and result registers.
module ole_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ole_pkg::cmd_t                   cmd,
    output ole_pkg::dp_stat_t               stat,
    input  logic [ole_pkg::OPC_W-1:0]       opcode,
    input  logic [ole_pkg::POS_W-1:0]       position,
    input  logic [ole_pkg::KEY_W-1:0]       element_key,
    output logic [ole_pkg::STATUS_W-1:0]    status,
    output logic signed [ole_pkg::FOUND_W-1:0] found_position,
    output logic [ole_pkg::CNT_W-1:0]       entry_count
);
    import ole_pkg::*;

    logic [OPC_W-1:0]         opc_reg, opc_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [ELEMENT_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         tgt_reg, tgt_next;
    mode_t                    mode_reg, mode_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [FOUND_W-1:0]       found_reg, found_next;
    logic [CNT_W-1:0]         count_out_reg, count_out_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;
    logic [CNT_W-1:0]         idx_dn;
    logic [CNT_W-1:0]         idx_up;
    logic [CNT_W-1:0]         pos_ext;

    assign idx_dn  = idx_reg - CNT_W'(1);
    assign idx_up  = idx_reg + CNT_W'(1);
    assign pos_ext = CNT_W'(pos_reg);

    ole_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read address follows the walk direction
    always_comb
    begin
        unique case (mode_reg)
            MODE_GROW:   ram_raddr = idx_dn[ADDR_W-1:0];
            MODE_SHRINK: ram_raddr = idx_up[ADDR_W-1:0];
            default:     ram_raddr = idx_reg[ADDR_W-1:0];
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        stat.opc   = opc_reg;
        stat.legal = pos_ext < cnt_reg;
        stat.full  = cnt_reg == CNT_W'(CAPACITY);
        stat.grow  = mode_reg == MODE_GROW;
        stat.more  = (mode_reg == MODE_GROW) ? (idx_reg > tgt_reg) : (idx_up < cnt_reg);
        stat.match = ram_rdata == key_reg;
        stat.last  = idx_up >= cnt_reg;
    end

    // Execute one command per cycle
    always_comb
    begin
        opc_next       = opc_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        tgt_next       = tgt_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        count_out_next = count_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[ADDR_W-1:0];
        ram_wdata      = ram_rdata;
        unique case (cmd.op)
            DP_LOAD:
            begin
                opc_next = opcode;
                pos_next = position;
                key_next = element_key[ELEMENT_WIDTH-1:0];
            end
            DP_START_GROW:
            begin
                mode_next = MODE_GROW;
                idx_next  = cnt_reg;
                priority if (opc_reg == OP_INS_BEFORE)
                begin
                    tgt_next = pos_ext;
                end
                else if (opc_reg == OP_APPEND)
                begin
                    tgt_next = cnt_reg;
                end
                else
                begin
                    tgt_next = '0;
                end
            end
            DP_START_SHRINK:
            begin
                mode_next = MODE_SHRINK;
                idx_next  = pos_ext;
            end
            DP_START_SCAN:
            begin
                mode_next = MODE_SCAN;
                idx_next  = pos_ext;
            end
            DP_MOVE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                idx_next  = (mode_reg == MODE_GROW) ? idx_dn : idx_up;
            end
            DP_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = tgt_reg[ADDR_W-1:0];
                ram_wdata = key_reg;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            DP_DROP:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_OVERWRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_ext[ADDR_W-1:0];
                ram_wdata = key_reg;
            end
            DP_SCAN_NEXT:
            begin
                idx_next = idx_up;
            end
            DP_FINISH:
            begin
                status_next    = cmd.st;
                found_next     = cmd.hit ? FOUND_W'(idx_reg) : '1;
                count_out_next = cnt_reg;
            end
            default:
            begin
                // no datapath action (also read issue for a move)
            end
        endcase
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        opc_reg       <= opc_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        tgt_reg       <= tgt_next;
        mode_reg      <= mode_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        count_out_reg <= count_out_next;
    end

    assign status         = status_reg;
    assign found_position = signed'(found_reg);
    assign entry_count    = count_out_reg;

endmodule

// File: src/ole_ctrl.sv
// Controller: sequences each request through the datapath and drives the handshakes.
module ole_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ole_pkg::dp_stat_t stat,
    output ole_pkg::cmd_t     cmd
);
    import ole_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOOP,
        S_MOVE_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    status_t st_reg, st_next;
    logic    hit_reg, hit_next;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        st_next        = st_reg;
        hit_next       = hit_reg;
        cmd.op         = DP_NOP;
        cmd.st         = st_reg;
        cmd.hit        = hit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next    = ST_OK;
                hit_next   = 1'b0;
                state_next = S_DONE;
                unique case (stat.opc)
                    OP_INS_BEFORE:
                    begin
                        priority if (!stat.legal)
                        begin
                            st_next = ST_ILLEGAL;
                        end
                        else if (stat.full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = DP_START_GROW;
                            state_next = S_LOOP;
                        end
                    end
                    OP_INS_START, OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = DP_START_GROW;
                            state_next = S_LOOP;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.legal)
                        begin
                            st_next = ST_ILLEGAL;
                        end
                        else
                        begin
                            cmd.op     = DP_START_SHRINK;
                            state_next = S_LOOP;
                        end
                    end
                    OP_OVERWRITE:
                    begin
                        if (!stat.legal)
                        begin
                            st_next = ST_ILLEGAL;
                        end
                        else
                        begin
                            cmd.op = DP_OVERWRITE;
                        end
                    end
                    OP_FIND:
                    begin
                        if (!stat.legal)
                        begin
                            st_next = ST_ILLEGAL;
                        end
                        else
                        begin
                            cmd.op     = DP_START_SCAN;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        // unused opcode: no operation
                    end
                endcase
            end
            S_LOOP:
            begin
                if (stat.more)
                begin
                    cmd.op     = DP_MOVE_RD;
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    cmd.op     = stat.grow ? DP_PUT : DP_DROP;
                    state_next = S_DONE;
                end
            end
            S_MOVE_WR:
            begin
                cmd.op     = DP_MOVE_WR;
                state_next = S_LOOP;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                priority if (stat.match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                // Publish once the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            st_reg        <= ST_OK;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            hit_reg       <= hit_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
